FILE: hdl/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescape decoder.
`timescale 1ns / 1ps

package jsu_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_OPEN   = 2'd1;
    localparam logic [1:0] ERR_ESCAPE = 2'd2;
    localparam logic [1:0] ERR_HEX    = 2'd3;

    // Characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One decoded input word: up to three result words
    typedef struct packed {
        logic [1:0] count;   // results to emit, 1..3
        logic [1:0] kind;
        logic [1:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } job_t;

    typedef struct packed {
        phase_t     phase;
    } front_stat_t;

    typedef struct packed {
        logic [1:0] idx;
    } back_stat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.val = c[3:0];
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            h.val = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // UTF-8 encode of a 16-bit code point
    function automatic job_t encode_utf8(input logic [15:0] cp);
        job_t j;
        j.kind = KIND_DATA;
        j.err  = ERR_NONE;
        j.b1   = 8'd0;
        j.b2   = 8'd0;
        if (cp <= 16'h007f) begin
            j.count = 2'd1;
            j.b0    = {1'b0, cp[6:0]};
        end
        else if (cp <= 16'h07ff) begin
            j.count = 2'd2;
            j.b0    = {3'b110, cp[10:6]};
            j.b1    = {2'b10, cp[5:0]};
        end
        else begin
            j.count = 2'd3;
            j.b0    = {4'b1110, cp[15:12]};
            j.b1    = {2'b10, cp[11:6]};
            j.b2    = {2'b10, cp[5:0]};
        end
        return j;
    endfunction

endpackage

FILE: hdl/jsu_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] err_code;
    logic       last;

    modport source (output valid, output kind, output out_byte, output err_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input err_code,
                    input last, output ready);
endinterface

FILE: hdl/jsu_front.sv
// Front end: accepts raw bytes, tracks the string phase and forms result jobs.
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jsu_in_if.sink       in_ch,
    input  logic         fifo_full,
    output logic         push,
    output job_t         job,
    output front_stat_t  stat
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  digit_reg, digit_next;
    logic [11:0] accum_reg, accum_next;
    logic        take;
    hex_t        hx;
    logic [15:0] cp;

    assign in_ch.ready = !fifo_full;
    assign take        = in_ch.valid && in_ch.ready;
    assign hx          = hex_value(in_ch.in_byte);
    assign cp          = {accum_reg, hx.val};
    assign stat.phase  = phase_reg;

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        accum_next = accum_reg;
        if (take)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (in_ch.in_byte == CH_QUOTE)
                    begin
                        phase_next = PH_STR;
                    end
                end
                PH_STR:
                begin
                    if (in_ch.in_byte == CH_QUOTE)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (in_ch.in_byte == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_STR;
                    digit_next = 2'd0;
                    accum_next = 12'd0;
                    if (in_ch.in_byte == CH_U)
                    begin
                        phase_next = PH_HEX;
                    end
                    else if (!(in_ch.in_byte inside {CH_QUOTE, CH_BSLASH, CH_SLASH,
                                                       CH_B, CH_F, CH_N, CH_R, CH_T}))
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_HEX:
                begin
                    if (!hx.ok)
                    begin
                        phase_next = PH_WAIT;
                        digit_next = 2'd0;
                        accum_next = 12'd0;
                    end
                    else if (digit_reg != 2'd3)
                    begin
                        accum_next = {accum_reg[7:0], hx.val};
                        digit_next = digit_reg + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_STR;
                        digit_next = 2'd0;
                        accum_next = 12'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    // Job forming
    always_comb
    begin
        job.count = 2'd0;
        job.kind  = KIND_DATA;
        job.err   = ERR_NONE;
        job.b0    = 8'd0;
        job.b1    = 8'd0;
        job.b2    = 8'd0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (in_ch.in_byte != CH_QUOTE)
                begin
                    job.count = 2'd1;
                    job.kind  = KIND_ERR;
                    job.err   = ERR_OPEN;
                end
            end
            PH_STR:
            begin
                if (in_ch.in_byte == CH_QUOTE)
                begin
                    job.count = 2'd1;
                    job.kind  = KIND_END;
                end
                else if (in_ch.in_byte != CH_BSLASH)
                begin
                    job.count = 2'd1;
                    job.b0    = in_ch.in_byte;
                end
            end
            PH_ESC:
            begin
                job.count = 2'd1;
                case (in_ch.in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: job.b0 = in_ch.in_byte;
                    CH_B:    job.b0 = CH_BS;
                    CH_F:    job.b0 = CH_FF;
                    CH_N:    job.b0 = CH_LF;
                    CH_R:    job.b0 = CH_CR;
                    CH_T:    job.b0 = CH_TAB;
                    CH_U:    job.count = 2'd0;
                    default:
                    begin
                        job.kind = KIND_ERR;
                        job.err  = ERR_ESCAPE;
                    end
                endcase
            end
            PH_HEX:
            begin
                if (!hx.ok)
                begin
                    job.count = 2'd1;
                    job.kind  = KIND_ERR;
                    job.err   = ERR_HEX;
                end
                else if (digit_reg == 2'd3)
                begin
                    job = encode_utf8(cp);
                end
            end
            default:
            begin
                job.count = 2'd0;
            end
        endcase
    end

    assign push = take && (job.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            digit_reg <= 2'd0;
            accum_reg <= 12'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            accum_reg <= accum_next;
        end
    end

endmodule

FILE: hdl/jsu_fifo.sv
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module jsu_fifo
    import jsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  job_t               push_job,
    input  logic               pop,
    output job_t               head,
    output logic               head_valid,
    output logic               full,
    output logic [FIFO_AW:0]   count
);

    job_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wptr_reg, wptr_next;
    logic [FIFO_AW-1:0]  rptr_reg, rptr_next;
    logic [FIFO_AW:0]    count_reg, count_next;
    logic                do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head       = mem_reg[rptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/jsu_back.sv
// Back end: steps through the bytes of each job into the output register.
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  job_t         head,
    input  logic         head_valid,
    output logic         pop,
    output back_stat_t   stat,
    jsu_out_if.source    out_ch
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [1:0] err_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = head_valid && (!valid_reg || out_ch.ready);
    assign is_last = (idx_reg == head.count - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            2'd2:    sel_byte = head.b2;
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head.kind;
            byte_reg <= sel_byte;
            err_reg  <= head.err;
            last_reg <= is_last;
        end
    end

    assign out_ch.valid    = valid_reg;
    assign out_ch.kind     = kind_reg;
    assign out_ch.out_byte = byte_reg;
    assign out_ch.err_code = err_reg;
    assign out_ch.last     = last_reg;
    assign stat.idx        = idx_reg;

endmodule

FILE: hdl/json_string_unescape_decoder_core.sv
// Top level of the JSON string unescape decoder.
`timescale 1ns / 1ps
//
// Feed one raw byte of a quoted JSON string per input word on in_ch; decoded
// words come out on out_ch with kind (data, end of string, error), out_byte,
// err_code and last, which marks the final word caused by one input byte.
// Both channels use valid/ready; a word moves when both are high.
//
// The front end classifies each byte in the cycle it is accepted and pushes
// a job of one to three result words into a four-entry queue. The back end
// drains the queue one result word per cycle while the receiver is ready
// into an output register. The first result word passes through the queue
// and the output register after its input word is accepted. An input word
// is taken every cycle while the queue has room; plain bytes, simple escapes,
// end and error words sustain one word per cycle. A \uXXXX escape takes six
// input words and gives at most three result words, so the output side keeps
// up with the input; only a stalled receiver slows the input down.
//
// Reset clears the phase to awaiting the opening quote and empties the queue.
// When the receiver stalls, the output word holds, the queue fills, and
// in_ch.ready drops once all four entries are taken.

module json_string_unescape_decoder_core
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jsu_in_if.sink      in_ch,
    jsu_out_if.source   out_ch
);

    job_t              push_job;
    job_t              head;
    logic              push;
    logic              pop;
    logic              head_valid;
    logic              fifo_full;
    logic [FIFO_AW:0]  fifo_count;
    front_stat_t       fstat;
    back_stat_t        bstat;

    // Classify input bytes and form jobs
    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .fifo_full (fifo_full),
        .push      (push),
        .job       (push_job),
        .stat      (fstat)
    );

    // Decouple front and back
    jsu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (fifo_full),
        .count      (fifo_count)
    );

    // Serialize jobs into result words
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .stat       (bstat),
        .out_ch     (out_ch)
    );

    // A partly emitted job must still sit at the queue head
    a_idx_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (bstat.idx != 2'd0) |-> head_valid)
        else $error("sequencer mid-job with empty queue");

    // Queue occupancy stays within its depth
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("job queue overflow");

    // End and error words are always the final word of their input byte
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.kind != KIND_DATA)) |-> out_ch.last)
        else $error("end or error word without last");

    // A stray byte before the opening quote must queue an error job
    a_open_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (fstat.phase == PH_WAIT) &&
         (in_ch.in_byte != CH_QUOTE)) |=> (fifo_count != '0))
        else $error("missing opening quote produced no job");

endmodule
